// ===== design/pts_reorder_buffer_select_macros.svh =====
// ----------------------------------------------------------------------------
// pts reorder buffer assertion macros
// concurrent assertion shorthands used by the port-level checker in prbs_checker.sv
// ----------------------------------------------------------------------------
`ifndef PTS_REORDER_BUFFER_SELECT_MACROS_SVH
`define PTS_REORDER_BUFFER_SELECT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PRBS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("prbs assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PRBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("prbs assertion failed");

`endif

// ===== design/prbs_pkg.sv =====
// ----------------------------------------------------------------------------
// prbs_pkg
// types and constants of the timestamp reorder buffer
// ----------------------------------------------------------------------------
package prbs_pkg;

    localparam int PTS_W   = 64;
    localparam int TAG_W   = 16;
    localparam int AGE_W   = 6;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic [AGE_W-1:0] AGE_MAX         = 6'd63;
    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 6'd16;

    // register index, taken from paddr above the byte offset
    localparam logic [PADDR_W-3:0] REG_AGE_LIMIT = 1'b0;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_REMOVE = 3'b100
    } prbs_state_t;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] age);
        logic [AGE_W-1:0] res;
        res = (age == AGE_MAX) ? age : age + 1'b1;
        return res;
    endfunction

endpackage

// ===== design/prbs_in_if.sv =====
// ----------------------------------------------------------------------------
// prbs_in_if
// input channel: insert or drain requests with frame timestamp and tag
// ----------------------------------------------------------------------------
interface prbs_in_if
    import prbs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [PTS_W-1:0] frame_pts;
    logic        [TAG_W-1:0] frame_tag;

    modport source (output valid, output op, output frame_pts, output frame_tag,
                    input ready);
    modport sink   (input valid, input op, input frame_pts, input frame_tag,
                    output ready);
endinterface

// ===== design/prbs_out_if.sv =====
// ----------------------------------------------------------------------------
// prbs_out_if
// output channel: frames selected for display
// ----------------------------------------------------------------------------
interface prbs_out_if
    import prbs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic        [TAG_W-1:0] out_tag;
    logic signed [PTS_W-1:0] out_pts;
    logic                    was_forced;
    logic                    last;

    modport source (output valid, output out_tag, output out_pts, output was_forced,
                    output last, input ready);
    modport sink   (input valid, input out_tag, input out_pts, input was_forced,
                    input last, output ready);
endinterface

// ===== design/prbs_cfg.sv =====
// ----------------------------------------------------------------------------
// prbs_cfg
// apb register block holding the starvation age limit
// ----------------------------------------------------------------------------
module prbs_cfg
    import prbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output logic [AGE_W-1:0]   age_limit
);

    logic [AGE_W-1:0]   age_limit_reg;
    logic [PADDR_W-3:0] reg_index;
    logic               wr_en;

    assign reg_index = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && (reg_index == REG_AGE_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= AGE_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            age_limit_reg <= pwdata[AGE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_AGE_LIMIT)
        begin
            prdata = {{(DATA_W-AGE_W){1'b0}}, age_limit_reg};
        end
    end

    assign age_limit = age_limit_reg;

endmodule

// ===== design/pts_reorder_buffer_select.sv =====
// an insert that fills the buffer scans all held entries in ST_SCAN, then ST_REMOVE stores its result
// a drain repeats the scan of the remaining entries and the removal for each result while entries remain
// throughput: one selection scans the held entries one per cycle through a single comparator
// the input is not ready from a filling insert or drain until its last selection is stored
// reset: asynchronous, active low; empties the buffer and sets age_limit to 16, no sweep
// ----------------------------------------------------------------------------
// pts_reorder_buffer_select
// timestamp reorder buffer with starvation guard for invalid timestamps
// ----------------------------------------------------------------------------
module pts_reorder_buffer_select
    import prbs_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    prbs_in_if.sink            frames,
    prbs_out_if.source         results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [AGE_W-1:0] age_limit;

    prbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .age_limit (age_limit)
    );

    // entry storage, oldest at index 0
    logic [PTS_W-1:0] pts_mem [DEPTH];
    logic [TAG_W-1:0] tag_mem [DEPTH];
    logic [AGE_W-1:0] age_mem [DEPTH];

    prbs_state_t      state_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             drain_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [PTS_W-1:0] best_pts_reg;
    logic             forced_reg;
    logic [IDX_W-1:0] forced_idx_reg;

    logic             out_valid_reg;
    logic [TAG_W-1:0] out_tag_reg;
    logic [PTS_W-1:0] out_pts_reg;
    logic             out_forced_reg;
    logic             out_last_reg;

    logic             in_xfer;
    logic             do_insert;
    logic [CNT_W-1:0] fill_inc;
    logic [IDX_W-1:0] sel_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [PTS_W-1:0] rd_pts;
    logic [TAG_W-1:0] rd_tag;
    logic [AGE_W-1:0] rd_age;
    logic             force_hit;
    logic             better;
    logic             scan_done;
    logic             out_free;
    logic             remove_fire;

    assign frames.ready = (state_reg == ST_IDLE);
    assign in_xfer      = frames.valid && frames.ready;
    assign do_insert    = in_xfer && (frames.op == OP_INSERT) && (fill_reg < CNT_W'(DEPTH));
    assign fill_inc     = fill_reg + 1'b1;

    assign sel_idx = forced_reg ? forced_idx_reg : best_idx_reg;
    assign rd_addr = (state_reg == ST_REMOVE) ? sel_idx : idx_reg;
    assign rd_pts  = pts_mem[rd_addr];
    assign rd_tag  = tag_mem[rd_addr];
    assign rd_age  = age_mem[rd_addr];

    // the sign bit marks an invalid timestamp
    assign force_hit = (rd_age > age_limit) && rd_pts[PTS_W-1];
    assign better    = !rd_pts[PTS_W-1] && (best_pts_reg[PTS_W-1] || (rd_pts < best_pts_reg));
    assign scan_done = (CNT_W'(idx_reg) == (fill_reg - 1'b1));

    assign out_free    = !out_valid_reg || results.ready;
    assign remove_fire = (state_reg == ST_REMOVE) && out_free;

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            pts_mem[fill_reg[IDX_W-1:0]] <= frames.frame_pts;
            tag_mem[fill_reg[IDX_W-1:0]] <= frames.frame_tag;
            age_mem[fill_reg[IDX_W-1:0]] <= '0;
        end
        else if (remove_fire)
        begin
            // close the gap and age every survivor
            for (int i = 0; i < DEPTH; i++)
            begin
                if ((i < DEPTH - 1) && (IDX_W'(i) >= sel_idx))
                begin
                    pts_mem[i] <= pts_mem[(i + 1) % DEPTH];
                    tag_mem[i] <= tag_mem[(i + 1) % DEPTH];
                    age_mem[i] <= age_inc(age_mem[(i + 1) % DEPTH]);
                end
                else
                begin
                    age_mem[i] <= age_inc(age_mem[i]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            drain_reg     <= 1'b0;
            forced_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (remove_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_xfer)
                    begin
                        if (frames.op == OP_INSERT)
                        begin
                            if (do_insert)
                            begin
                                fill_reg <= fill_inc;
                                if (fill_inc == CNT_W'(DEPTH))
                                begin
                                    drain_reg <= 1'b0;
                                    state_reg <= ST_SCAN;
                                end
                            end
                        end
                        else if (fill_reg != '0)
                        begin
                            drain_reg <= 1'b1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg == '0)
                    begin
                        forced_reg <= force_hit;
                    end
                    else if (!forced_reg && force_hit)
                    begin
                        forced_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        state_reg <= ST_REMOVE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_REMOVE:
                begin
                    if (out_free)
                    begin
                        fill_reg <= fill_reg - 1'b1;
                        idx_reg  <= '0;
                        if (drain_reg && (fill_reg != CNT_W'(1)))
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // scan datapath: earliest valid timestamp and first starved entry
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
        begin
            if (idx_reg == '0)
            begin
                best_idx_reg   <= '0;
                best_pts_reg   <= rd_pts;
                forced_idx_reg <= '0;
            end
            else
            begin
                if (better)
                begin
                    best_idx_reg <= idx_reg;
                    best_pts_reg <= rd_pts;
                end
                if (!forced_reg && force_hit)
                begin
                    forced_idx_reg <= idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (remove_fire)
        begin
            out_tag_reg    <= rd_tag;
            out_pts_reg    <= rd_pts;
            out_forced_reg <= forced_reg;
            out_last_reg   <= !drain_reg || (fill_reg == CNT_W'(1));
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_tag    = out_tag_reg;
    assign results.out_pts    = out_pts_reg;
    assign results.was_forced = out_forced_reg;
    assign results.last       = out_last_reg;

endmodule

// ===== design/prbs_checker.sv =====
// ----------------------------------------------------------------------------
// prbs_checker
// port-level checks of the reorder buffer, bound to the top level
// ----------------------------------------------------------------------------
`include "pts_reorder_buffer_select_macros.svh"

module prbs_checker
    import prbs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [TAG_W-1:0] out_tag,
    input logic [PTS_W-1:0] out_pts,
    input logic             out_forced,
    input logic             out_last
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    `PRBS_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_stall, out_valid)

    `PRBS_ASSERT_NEXT(a_out_payload_holds, clk, rst_n, out_stall,
        $stable(out_tag) && $stable(out_pts) && $stable(out_forced) && $stable(out_last))

    // a selection passes through ST_SCAN before it is stored
    `PRBS_ASSERT_NEXT(a_no_result_right_after_input, clk, rst_n, in_xfer, !$rose(out_valid))

    // after a non-final drain transfer the block is busy or already holds the next result
    `PRBS_ASSERT_NEXT(a_drain_keeps_busy, clk, rst_n, out_valid && out_ready && !out_last,
        !in_ready || out_valid)

endmodule

bind pts_reorder_buffer_select prbs_checker u_prbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (frames.valid),
    .in_ready   (frames.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_tag    (results.out_tag),
    .out_pts    (results.out_pts),
    .out_forced (results.was_forced),
    .out_last   (results.last)
);

// ===== tb/pts_reorder_buffer_select_checker.sv =====
// ----------------------------------------------------------------------------
// pts_reorder_buffer_select_checker
// watches the frame, result and register ports, keeps its own copy of the
// reorder buffer and compares every displayed frame with its prediction
// ----------------------------------------------------------------------------
module pts_reorder_buffer_select_checker
    import prbs_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    prbs_in_if                 frames,
    prbs_out_if                results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output int                 outstanding,
    output int                 fail_count
);

    typedef struct {
        logic        [TAG_W-1:0] tag;
        logic signed [PTS_W-1:0] pts;
        logic                    forced;
        logic                    last;
    } shown_frame_t;

    logic signed [PTS_W-1:0] held_pts [DEPTH];
    logic        [TAG_W-1:0] held_tag [DEPTH];
    logic        [AGE_W-1:0] held_age [DEPTH];
    int                      held_count = 0;
    logic        [AGE_W-1:0] age_limit  = AGE_LIMIT_RESET;
    shown_frame_t            display_q [$];
    int                      errors     = 0;

    // choose one held frame, queue it for display and close the gap it leaves
    task automatic pick_for_display(input logic is_last);
        int           best;
        logic         forced;
        shown_frame_t pick;
        best   = 0;
        forced = 1'b0;
        // starvation guard: first invalid frame passed over too often
        for (int i = 0; i < held_count; i++)
        begin
            if (!forced && held_pts[i][PTS_W-1] && held_age[i] > age_limit)
            begin
                best   = i;
                forced = 1'b1;
            end
        end
        if (!forced)
        begin
            // earliest valid timestamp, the older frame keeps a tie
            for (int i = 1; i < held_count; i++)
            begin
                if (!held_pts[i][PTS_W-1] &&
                    (held_pts[best][PTS_W-1] || held_pts[i] < held_pts[best]))
                    best = i;
            end
        end
        pick.tag    = held_tag[best];
        pick.pts    = held_pts[best];
        pick.forced = forced;
        pick.last   = is_last;
        display_q   = {display_q, pick};
        for (int i = best; i + 1 < held_count; i++)
        begin
            held_pts[i] = held_pts[i + 1];
            held_tag[i] = held_tag[i + 1];
            held_age[i] = held_age[i + 1];
        end
        held_count--;
        for (int i = 0; i < held_count; i++)
        begin
            if (held_age[i] != AGE_MAX)
                held_age[i] = held_age[i] + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        shown_frame_t want;
        if (!rst_n)
        begin
            held_count = 0;
            age_limit  = AGE_LIMIT_RESET;
            display_q.delete();
            outstanding <= 0;
            fail_count  <= errors;
        end
        else
        begin
            if (psel && penable && pwrite && pready &&
                paddr[PADDR_W-1:2] == REG_AGE_LIMIT)
                age_limit = pwdata[AGE_W-1:0];

            if (results.valid && results.ready)
            begin
                if (display_q.size() == 0)
                begin
                    $error("unexpected result transfer: out_tag %h out_pts %h",
                           results.out_tag, results.out_pts);
                    errors++;
                end
                else
                begin
                    want = display_q.pop_front();
                    if (results.out_tag !== want.tag)
                    begin
                        $error("out_tag: expected %h, actual %h", want.tag, results.out_tag);
                        errors++;
                    end
                    if (results.out_pts !== want.pts)
                    begin
                        $error("out_pts: expected %h, actual %h", want.pts, results.out_pts);
                        errors++;
                    end
                    if (results.was_forced !== want.forced)
                    begin
                        $error("was_forced: expected %b, actual %b",
                               want.forced, results.was_forced);
                        errors++;
                    end
                    if (results.last !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, results.last);
                        errors++;
                    end
                end
            end

            if (frames.valid && frames.ready)
            begin
                if (frames.op == OP_INSERT)
                begin
                    if (held_count < DEPTH)
                    begin
                        held_pts[held_count] = frames.frame_pts;
                        held_tag[held_count] = frames.frame_tag;
                        held_age[held_count] = '0;
                        held_count++;
                    end
                    if (held_count >= DEPTH)
                        pick_for_display(1'b1);
                end
                else
                begin
                    while (held_count > 0)
                        pick_for_display(held_count == 1);
                end
            end

            outstanding <= display_q.size();
            fail_count  <= errors;
        end
    end

endmodule

// ===== tb/pts_reorder_buffer_select_test.sv =====
// ----------------------------------------------------------------------------
// pts_reorder_buffer_select_test
// drives frames, drains and age limit writes into the reorder buffer with
// random gaps and stalls; the checker beside the block judges the results
// ----------------------------------------------------------------------------
module pts_reorder_buffer_select_test;
    import prbs_pkg::*;

    localparam int DEPTH           = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int PHASES          = 6;
    localparam int SETTLE_CYCLES   = 40;
    localparam int IDLE_LIMIT      = 2000;
    localparam int MAX_WAIT        = 14;

    // second register slot, not mapped in the block
    localparam logic [PADDR_W-3:0] REG_UNMAPPED = 1'b1;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    int                 outstanding;
    int                 fail_count;

    logic                    send_burst = 1'b0;
    logic                    take_burst = 1'b0;
    logic signed [PTS_W-1:0] pts_clock  = '0;
    logic signed [PTS_W-1:0] prev_pts   = '0;

    prbs_in_if  frames_if ();
    prbs_out_if results_if ();

    pts_reorder_buffer_select #(
        .DEPTH (DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frames  (frames_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pts_reorder_buffer_select_checker #(
        .DEPTH (DEPTH)
    ) checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .frames      (frames_if),
        .results     (results_if),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always #1 clk = ~clk;

    function automatic int draw_wait(input logic burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic offer_frame(input logic op, input logic signed [PTS_W-1:0] pts,
                               input logic [TAG_W-1:0] tag);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_burst = ~send_burst;
        gap = draw_wait(send_burst);
        if (gap > 0)
        begin
            frames_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frames_if.valid     <= 1'b1;
        frames_if.op        <= op;
        frames_if.frame_pts <= pts;
        frames_if.frame_tag <= tag;
        do @(posedge clk); while (!frames_if.ready);
    endtask

    task automatic wait_idle;
        frames_if.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [PADDR_W-3:0] idx, input logic [AGE_W-1:0] value);
        logic [DATA_W-1:0] noise;
        noise   = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {noise[DATA_W-1:AGE_W], value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly a rising timestamp clock with jitter, plus invalid, wild and tied values
    task automatic random_frame;
        logic                    op;
        logic signed [PTS_W-1:0] pts;
        logic        [TAG_W-1:0] tag;
        int                      pick;
        pick = $urandom_range(0, 99);
        op   = OP_INSERT;
        tag  = TAG_W'($urandom_range(0, 16'hFFFF));
        if (pick < 5)
        begin
            op  = OP_DRAIN;
            pts = {$urandom, $urandom};
        end
        else if (pick < 60)
        begin
            pts_clock = pts_clock + $urandom_range(1, 4);
            pts       = pts_clock + $urandom_range(0, 15);
        end
        else if (pick < 72)
            pts = {$urandom, $urandom};
        else if (pick < 88)
        begin
            pts            = {$urandom, $urandom};
            pts[PTS_W-1]   = 1'b1;
        end
        else
            pts = prev_pts;
        if (op == OP_INSERT)
            prev_pts = pts;
        offer_frame(op, pts, tag);
    endtask

    initial
    begin : result_sink
        int stall;
        results_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                take_burst = ~take_burst;
            stall = draw_wait(take_burst);
            if (stall > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            do @(posedge clk); while (!results_if.valid);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((frames_if.valid && frames_if.ready) ||
                (results_if.valid && results_if.ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [AGE_W-1:0] phase_limit [PHASES];
        phase_limit[0] = AGE_LIMIT_RESET;
        phase_limit[1] = 6'd0;
        phase_limit[2] = 6'd62;
        phase_limit[3] = AGE_MAX;
        phase_limit[4] = 6'd5;
        phase_limit[5] = AGE_W'($urandom_range(0, 62));

        frames_if.valid     <= 1'b0;
        frames_if.op        <= OP_INSERT;
        frames_if.frame_pts <= '0;
        frames_if.frame_tag <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        rst_n   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drain of an empty buffer, frame fields carry junk
        offer_frame(OP_DRAIN, 64'sh5A5A_A5A5_5A5A_A5A5, 16'hA5A5);
        // field extremes and a tie; the eighth insert fills the buffer
        offer_frame(OP_INSERT, 64'sh0, 16'h0000);
        offer_frame(OP_INSERT, 64'sh7FFF_FFFF_FFFF_FFFF, 16'hFFFF);
        offer_frame(OP_INSERT, -64'sd1, 16'h0001);
        offer_frame(OP_INSERT, 64'sh8000_0000_0000_0000, 16'h8000);
        offer_frame(OP_INSERT, 64'sd5, 16'h0005);
        offer_frame(OP_INSERT, 64'sd5, 16'h0006);
        offer_frame(OP_INSERT, 64'sd3, 16'h0007);
        offer_frame(OP_INSERT, 64'sd1, 16'h0008);
        offer_frame(OP_INSERT, 64'sd2, 16'h0009);
        offer_frame(OP_DRAIN, -64'sd1, 16'hFFFF);
        // all timestamps invalid: oldest goes first
        for (int i = 0; i < DEPTH; i++)
            offer_frame(OP_INSERT, {1'b1, 31'($urandom), 32'($urandom)},
                        TAG_W'(16'h0100 + i));
        offer_frame(OP_DRAIN, 64'sh0, 16'h0000);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                repeat (SETTLE_CYCLES) @(posedge clk);
                write_reg(REG_AGE_LIMIT, phase_limit[p]);
                // a write to the unmapped slot must leave the limit alone
                if (p == 4)
                    write_reg(REG_UNMAPPED, AGE_MAX);
            end
            repeat (ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_idle();
                random_frame();
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/prbs_pkg.sv
design/prbs_in_if.sv
design/prbs_out_if.sv
design/prbs_cfg.sv
design/pts_reorder_buffer_select.sv
design/prbs_checker.sv
tb/pts_reorder_buffer_select_checker.sv
tb/pts_reorder_buffer_select_test.sv
